### hdl/dhcp_lease_allocator_unit_defines.svh
// assertion macros used by the lease allocator controller
`ifndef DHCP_LEASE_ALLOCATOR_UNIT_DEFINES_SVH
`define DHCP_LEASE_ALLOCATOR_UNIT_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define DLA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define DLA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/dla_pkg.sv
package dla_pkg;

	localparam int MAC_W = 48;

	// header check values
	localparam logic [7:0]  OP_REQUEST   = 8'd1;
	localparam logic [31:0] COOKIE_VALUE = 32'h63825363;
	localparam logic [7:0]  MSG_DISCOVER = 8'd1;
	localparam logic [7:0]  MSG_REQUEST  = 8'd3;

	// configuration register indexes
	localparam logic [1:0] REG_SERVER_ADDR = 2'd0;
	localparam logic [1:0] REG_POOL_BASE   = 2'd1;

	localparam logic [31:0] SERVER_ADDR_RESET = 32'd0;
	localparam logic [7:0]  POOL_BASE_RESET   = 8'd16;

	typedef enum logic [1:0] {
		ACT_DROP  = 2'd0,
		ACT_OFFER = 2'd1,
		ACT_ACK   = 2'd2,
		ACT_ALLOC = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'd0,
		ST_MATCH = 2'd1,
		ST_CLAIM = 2'd2
	} state_t;

endpackage

### hdl/dla_lease_ram.sv
module dla_lease_ram import dla_pkg::*; #(
	parameter int NUM_LEASES = 8,
	localparam int IW = (NUM_LEASES > 1) ? $clog2(NUM_LEASES) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             we,
	input  logic [IW-1:0]    waddr,
	input  logic [MAC_W-1:0] wdata,
	input  logic [IW-1:0]    raddr,
	output logic [MAC_W-1:0] rdata
);

	logic [MAC_W-1:0]      mem_q [NUM_LEASES];
	logic [NUM_LEASES-1:0] valid_q;
	logic [MAC_W-1:0]      rd_q;
	logic                  rd_vld_q;

	// table storage with registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rd_q <= mem_q[raddr];
	end

	// per-entry written flags, a never-written entry reads as free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
			rd_vld_q <= valid_q[raddr];
		end
	end

	assign rdata = rd_vld_q ? rd_q : '0;

endmodule

### hdl/dla_ctrl.sv
`include "dhcp_lease_allocator_unit_defines.svh"

module dla_ctrl import dla_pkg::*; #(
	parameter int NUM_LEASES = 8,
	localparam int IW = (NUM_LEASES > 1) ? $clog2(NUM_LEASES) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic             length_ok,
	input  logic [7:0]       op_code,
	input  logic [31:0]      magic_word,
	input  logic [7:0]       message_type,
	input  logic [MAC_W-1:0] client_mac,
	input  logic [31:0]      server_address,
	input  logic [7:0]       pool_base_offset,
	output logic             ram_we,
	output logic [IW-1:0]    ram_waddr,
	output logic [MAC_W-1:0] ram_wdata,
	output logic [IW-1:0]    ram_raddr,
	input  logic [MAC_W-1:0] ram_rdata,
	output logic             done,
	output logic [1:0]       action,
	output logic [2:0]       lease_slot,
	output logic [31:0]      offer_address
);

	localparam logic [IW-1:0] LAST_IDX = IW'(NUM_LEASES - 1);

	state_t           state_q, state_d;
	logic [IW-1:0]    rd_ptr_q;
	logic [IW-1:0]    cmp_idx_q;
	logic             cmp_vld_q;
	logic [MAC_W-1:0] mac_q;
	logic [7:0]       type_q;
	logic             done_q;
	action_t          action_q;
	logic [2:0]       slot_q;
	logic [31:0]      addr_q;

	logic             accept;
	logic             hdr_ok;
	logic [MAC_W-1:0] key;
	logic             hit;
	logic             at_last;
	logic             restart;
	logic             finish_hit;
	logic             finish_drop;
	action_t          act_d;

	assign accept  = start && (state_q == ST_IDLE);
	assign busy    = (state_q != ST_IDLE);
	assign hdr_ok  = length_ok && (op_code == OP_REQUEST) && (magic_word == COOKIE_VALUE);
	assign at_last = (cmp_idx_q == LAST_IDX);

	// shared compare unit: first pass looks for the mac, second for a free entry
	assign key = (state_q == ST_MATCH) ? mac_q : '0;
	assign hit = busy && cmp_vld_q && (ram_rdata == key);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && hdr_ok) begin
					state_d = ST_MATCH;
				end
			end
			ST_MATCH: begin
				if (hit) begin
					state_d = ST_IDLE;
				end else if (cmp_vld_q && at_last) begin
					state_d = ST_CLAIM;
				end
			end
			ST_CLAIM: begin
				if (hit || (cmp_vld_q && at_last)) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// sequencer outputs
	always_comb begin
		ram_we      = (state_q == ST_CLAIM) && hit;
		ram_waddr   = cmp_idx_q;
		ram_wdata   = mac_q;
		ram_raddr   = rd_ptr_q;
		restart     = (state_q == ST_MATCH) && !hit && cmp_vld_q && at_last;
		finish_hit  = hit;
		finish_drop = (accept && !hdr_ok)
			|| ((state_q == ST_CLAIM) && !hit && cmp_vld_q && at_last);
	end

	// reply kind from message type
	always_comb begin
		if (type_q == MSG_DISCOVER) begin
			act_d = ACT_OFFER;
		end else if (type_q == MSG_REQUEST) begin
			act_d = ACT_ACK;
		end else begin
			act_d = ACT_ALLOC;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			rd_ptr_q  <= '0;
			cmp_idx_q <= '0;
			cmp_vld_q <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= finish_hit || finish_drop;
			if (accept || restart) begin
				rd_ptr_q  <= '0;
				cmp_vld_q <= 1'b0;
			end else if (busy) begin
				if (rd_ptr_q != LAST_IDX) begin
					rd_ptr_q <= rd_ptr_q + IW'(1);
				end
				cmp_idx_q <= rd_ptr_q;
				cmp_vld_q <= 1'b1;
			end else begin
				cmp_vld_q <= 1'b0;
			end
		end
	end

	// item capture and result registers
	always_ff @(posedge clk) begin
		if (accept) begin
			mac_q  <= client_mac;
			type_q <= message_type;
		end
		if (finish_hit) begin
			action_q <= act_d;
			slot_q   <= 3'(cmp_idx_q);
			addr_q   <= {server_address[31:8],
				server_address[7:0] + pool_base_offset + 8'(cmp_idx_q)};
		end else if (finish_drop) begin
			action_q <= ACT_DROP;
			slot_q   <= '0;
			addr_q   <= '0;
		end
	end

	assign done          = done_q;
	assign action        = action_q;
	assign lease_slot    = slot_q;
	assign offer_address = addr_q;

	`DLA_ASSERT_NEXT(a_accept_progress, clk, arst_n, accept, busy || done,
		"accepted item neither searching nor dropped")
	`DLA_ASSERT_NOW(a_write_in_claim, clk, arst_n, ram_we,
		(state_q == ST_CLAIM) && cmp_vld_q, "table write outside free-entry search")
	`DLA_ASSERT_NOW(a_done_when_idle, clk, arst_n, done, state_q == ST_IDLE,
		"result strobe while still searching")
	`DLA_ASSERT_NOW(a_drop_zero, clk, arst_n, done && (action == ACT_DROP),
		(lease_slot == 3'd0) && (offer_address == 32'd0), "dropped result carries data")

endmodule

### hdl/dhcp_lease_allocator_unit.sv
// channel   direction  transfer when           payload
// command   in         start && !busy          length_ok, op_code, magic_word,
//                                              message_type, client_mac
// config    in         cfg_valid && cfg_ready  cfg_index, cfg_data
// result    out        done (one cycle)        action, lease_slot, offer_address
//
// a failed header check gives its result strobe in the cycle after start
// a known mac is found in the first pass over the table, a new client
// claims the first free entry in the second pass, a full table is dropped
// the search does one 48-bit compare per cycle behind the registered table read
// busy drops in the cycle of the strobe, so the next start may come right then
// arst_n frees the table (all entries free) and resets the config registers
// the receiver cannot stall; cfg_ready is always high
module dhcp_lease_allocator_unit import dla_pkg::*; #(
	parameter int NUM_LEASES = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        length_ok,
	input  logic [7:0]  op_code,
	input  logic [31:0] magic_word,
	input  logic [7:0]  message_type,
	input  logic [47:0] client_mac,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output logic        done,
	output logic [1:0]  action,
	output logic [2:0]  lease_slot,
	output logic [31:0] offer_address
);

	localparam int IW = (NUM_LEASES > 1) ? $clog2(NUM_LEASES) : 1;

	logic [31:0]      server_addr_q;
	logic [7:0]       pool_base_q;
	logic             ram_we;
	logic [IW-1:0]    ram_waddr;
	logic [MAC_W-1:0] ram_wdata;
	logic [IW-1:0]    ram_raddr;
	logic [MAC_W-1:0] ram_rdata;

	assign cfg_ready = 1'b1;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			server_addr_q <= SERVER_ADDR_RESET;
			pool_base_q   <= POOL_BASE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_SERVER_ADDR: server_addr_q <= cfg_data;
				REG_POOL_BASE:   pool_base_q   <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// lease table
	dla_lease_ram #(
		.NUM_LEASES(NUM_LEASES)
	) u_ram (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// header check, search sequencer and result registers
	dla_ctrl #(
		.NUM_LEASES(NUM_LEASES)
	) u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.length_ok       (length_ok),
		.op_code         (op_code),
		.magic_word      (magic_word),
		.message_type    (message_type),
		.client_mac      (client_mac),
		.server_address  (server_addr_q),
		.pool_base_offset(pool_base_q),
		.ram_we          (ram_we),
		.ram_waddr       (ram_waddr),
		.ram_wdata       (ram_wdata),
		.ram_raddr       (ram_raddr),
		.ram_rdata       (ram_rdata),
		.done            (done),
		.action          (action),
		.lease_slot      (lease_slot),
		.offer_address   (offer_address)
	);

endmodule

### test/tb.sv
`timescale 1ns / 100ps

module tb;
	import dla_pkg::*;

	localparam int NUM_LEASES = 8;
	localparam int MAC_POOL_SIZE = 12;
	localparam int PHASE_ITEMS = 105;

	// indexes past the two real registers, writes there must be ignored
	localparam logic [1:0] REG_SPARE_2 = 2'd2;
	localparam logic [1:0] REG_SPARE_3 = 2'd3;

	typedef struct packed {
		action_t     act;
		logic [2:0]  slot;
		logic [31:0] addr;
	} lease_reply_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic        length_ok = 1'b0;
	logic [7:0]  op_code = 8'd0;
	logic [31:0] magic_word = 32'd0;
	logic [7:0]  message_type = 8'd0;
	logic [47:0] client_mac = 48'd0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = 2'd0;
	logic [31:0] cfg_data = 32'd0;
	logic        done;
	logic [1:0]  action;
	logic [2:0]  lease_slot;
	logic [31:0] offer_address;

	// predictor state: lease table and config copies
	logic [47:0]  lease_table [NUM_LEASES];
	logic [31:0]  server_addr = SERVER_ADDR_RESET;
	logic [7:0]   pool_base = POOL_BASE_RESET;
	logic [47:0]  mac_pool [MAC_POOL_SIZE];
	lease_reply_t pending_replies [$];
	lease_reply_t oldest_reply;

	int fail_count = 0;
	int commands_sent = 0;
	int settings_used = 0;
	int offers_seen = 0;
	int acks_seen = 0;
	int allocs_seen = 0;
	int drops_seen = 0;

	dhcp_lease_allocator_unit #(
		.NUM_LEASES(NUM_LEASES)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.length_ok(length_ok),
		.op_code(op_code),
		.magic_word(magic_word),
		.message_type(message_type),
		.client_mac(client_mac),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.done(done),
		.action(action),
		.lease_slot(lease_slot),
		.offer_address(offer_address)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		foreach (lease_table[i]) lease_table[i] = '0;
	end

	// run limit, far above the slowest correct run
	initial begin
		#400_000;
		$display("%0t: timeout, %0d results still expected", $time, pending_replies.size());
		$display("Simulation FAILED");
		$finish;
	end

	// lease lookup: match the mac first, else claim the first free entry
	function automatic lease_reply_t predict_reply(input logic len_ok, input logic [7:0] op,
			input logic [31:0] magic, input logic [7:0] mtype, input logic [47:0] mac);
		lease_reply_t r;
		int slot;
		logic [7:0] last_octet;
		r.act = ACT_DROP;
		r.slot = '0;
		r.addr = '0;
		slot = -1;
		if (!len_ok || op != OP_REQUEST || magic != COOKIE_VALUE)
			return r;
		for (int i = 0; i < NUM_LEASES; i++)
			if (slot < 0 && lease_table[i] == mac) slot = i;
		for (int i = 0; i < NUM_LEASES; i++) begin
			if (slot < 0 && lease_table[i] == '0) begin
				slot = i;
				lease_table[i] = mac;
			end
		end
		if (slot < 0)
			return r;
		// last octet wraps, never carries into the third octet
		last_octet = server_addr[7:0] + pool_base + 8'(slot);
		r.addr = {server_addr[31:8], last_octet};
		r.slot = 3'(slot);
		case (mtype)
			MSG_DISCOVER: r.act = ACT_OFFER;
			MSG_REQUEST:  r.act = ACT_ACK;
			default:      r.act = ACT_ALLOC;
		endcase
		return r;
	endfunction

	function automatic logic [47:0] random_mac();
		logic [63:0] bits;
		bits = {$urandom(), $urandom()};
		return bits[47:0];
	endfunction

	// mostly back to back or short gaps, a few long ones
	function automatic int gap_cycles(input logic no_idle);
		int pick;
		pick = $urandom_range(0, 99);
		if (no_idle || pick < 55)
			return 0;
		if (pick < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// one command transfer; start stays high for the caller to lower or reuse
	task automatic send_cmd(input logic len_ok, input logic [7:0] op, input logic [31:0] magic,
			input logic [7:0] mtype, input logic [47:0] mac);
		start <= 1'b1;
		length_ok <= len_ok;
		op_code <= op;
		magic_word <= magic;
		message_type <= mtype;
		client_mac <= mac;
		do @(posedge clk); while (busy);
		pending_replies.push_back(predict_reply(len_ok, op, magic, mtype, mac));
		commands_sent++;
	endtask

	task automatic hold_off(input int cycles);
		if (cycles > 0) begin
			start <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	// sender waits until every expected result is back
	task automatic drain();
		start <= 1'b0;
		while (pending_replies.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_SERVER_ADDR: server_addr = data;
			REG_POOL_BASE:   pool_base = data[7:0];
			default:         ;
		endcase
	endtask

	// only called with the block idle
	task automatic configure(input logic [31:0] addr, input logic [7:0] base,
			input logic poke_spare);
		write_reg(REG_SERVER_ADDR, addr);
		if (poke_spare) begin
			write_reg(REG_SPARE_2, $urandom());
			write_reg(REG_SPARE_3, $urandom());
		end
		write_reg(REG_POOL_BASE, {24'($urandom()), base});
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	task automatic send_random();
		logic len_ok;
		logic [7:0] op;
		logic [31:0] magic;
		logic [7:0] mtype;
		logic [47:0] mac;
		int pick;
		len_ok = 1'b1;
		op = OP_REQUEST;
		magic = COOKIE_VALUE;
		// mostly well-formed headers, the rest broken in one way
		pick = $urandom_range(0, 99);
		if (pick < 8)
			len_ok = 1'b0;
		else if (pick < 16)
			op = 8'($urandom_range(0, 255));
		else if (pick < 22)
			magic = $urandom();
		else if (pick < 26)
			magic = COOKIE_VALUE ^ (32'd1 << $urandom_range(0, 31));
		pick = $urandom_range(0, 99);
		if (pick < 35)
			mtype = MSG_DISCOVER;
		else if (pick < 70)
			mtype = MSG_REQUEST;
		else
			mtype = 8'($urandom());
		// returning clients dominate, some zero macs and fresh ones
		pick = $urandom_range(0, 99);
		if (pick < 70)
			mac = mac_pool[$urandom_range(0, MAC_POOL_SIZE - 1)];
		else if (pick < 80)
			mac = '0;
		else
			mac = random_mac();
		send_cmd(len_ok, op, magic, mtype, mac);
	endtask

	// each broken header is dropped and claims nothing
	task automatic test_header_drops();
		logic [47:0] mac;
		mac = random_mac();
		send_cmd(1'b0, OP_REQUEST, COOKIE_VALUE, MSG_DISCOVER, mac);
		send_cmd(1'b1, 8'd0, COOKIE_VALUE, MSG_DISCOVER, mac);
		hold_off(2);
		send_cmd(1'b1, 8'hFF, COOKIE_VALUE, MSG_REQUEST, mac);
		send_cmd(1'b1, 8'd2, COOKIE_VALUE, MSG_DISCOVER, mac);
		send_cmd(1'b1, OP_REQUEST, COOKIE_VALUE ^ 32'd1, MSG_DISCOVER, mac);
		hold_off(1);
		send_cmd(1'b1, OP_REQUEST, 32'h0, MSG_DISCOVER, mac);
		send_cmd(1'b1, OP_REQUEST, 32'hFFFFFFFF, MSG_REQUEST, mac);
		drain();
	endtask

	// zero mac lands on the first free entry and leaves it free
	task automatic test_zero_mac();
		send_cmd(1'b1, OP_REQUEST, COOKIE_VALUE, MSG_REQUEST, 48'h0);
		send_cmd(1'b1, OP_REQUEST, COOKIE_VALUE, MSG_DISCOVER, 48'h0);
		hold_off(5);
		send_cmd(1'b1, OP_REQUEST, COOKIE_VALUE, 8'd0, 48'h0);
		drain();
	endtask

	// offer, ack and plain allocation, with rematch of a known client
	task automatic test_message_types();
		send_cmd(1'b1, OP_REQUEST, COOKIE_VALUE, MSG_DISCOVER, mac_pool[0]);
		send_cmd(1'b1, OP_REQUEST, COOKIE_VALUE, MSG_REQUEST, mac_pool[0]);
		send_cmd(1'b1, OP_REQUEST, COOKIE_VALUE, 8'd0, mac_pool[1]);
		hold_off(3);
		send_cmd(1'b1, OP_REQUEST, COOKIE_VALUE, 8'hFF, mac_pool[1]);
		send_cmd(1'b1, OP_REQUEST, COOKIE_VALUE, 8'd2, 48'hFFFF_FFFF_FFFF);
		drain();
	endtask

	// extreme settings, last octet wrap and writes to unused indexes
	task automatic test_config_extremes();
		configure(32'hFFFFFFFF, 8'hFF, 1'b1);
		send_cmd(1'b1, OP_REQUEST, COOKIE_VALUE, MSG_DISCOVER, mac_pool[0]);
		send_cmd(1'b1, OP_REQUEST, COOKIE_VALUE, MSG_REQUEST, 48'hFFFF_FFFF_FFFF);
		drain();
		configure(32'h0, 8'h0, 1'b0);
		send_cmd(1'b1, OP_REQUEST, COOKIE_VALUE, MSG_REQUEST, 48'hFFFF_FFFF_FFFF);
		drain();
		configure(32'hC0A800F8, 8'h10, 1'b1);
		send_cmd(1'b1, OP_REQUEST, COOKIE_VALUE, MSG_DISCOVER, mac_pool[1]);
		drain();
	endtask

	// random phases, each under its own setting
	task automatic test_random_traffic();
		logic [31:0] addr_set [6];
		logic [7:0] base_set [6];
		addr_set = '{32'hC0A80101, 32'hFFFFFFFF, 32'h0, $urandom(), 32'h0A0000F0, $urandom()};
		base_set = '{8'h10, 8'hFF, 8'h00, 8'($urandom()), 8'h20, 8'($urandom())};
		for (int p = 0; p < 6; p++) begin
			configure(addr_set[p], base_set[p], p == 3);
			repeat (PHASE_ITEMS) begin
				send_random();
				hold_off(gap_cycles(p == 2));
			end
			drain();
		end
	endtask

	// fill every remaining entry, then new clients are dropped
	task automatic test_table_full();
		int free_slots;
		free_slots = 0;
		foreach (lease_table[i])
			if (lease_table[i] == '0) free_slots++;
		for (int k = 0; k <= free_slots; k++) begin
			send_cmd(1'b1, OP_REQUEST, COOKIE_VALUE, MSG_DISCOVER, random_mac());
			hold_off(gap_cycles(1'b0));
		end
		send_cmd(1'b1, OP_REQUEST, COOKIE_VALUE, MSG_REQUEST, lease_table[NUM_LEASES - 1]);
		send_cmd(1'b1, OP_REQUEST, COOKIE_VALUE, MSG_DISCOVER, 48'h0);
		drain();
	endtask

	task automatic check_field(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
			fail_count++;
		end
	endtask

	// result check against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_replies.size() == 0) begin
				$display("%0t: unexpected result, action %0d slot %0d address %h",
					$time, action, lease_slot, offer_address);
				fail_count++;
			end else begin
				oldest_reply = pending_replies.pop_front();
				check_field("action", 32'(oldest_reply.act), 32'(action));
				check_field("lease_slot", 32'(oldest_reply.slot), 32'(lease_slot));
				check_field("offer_address", oldest_reply.addr, offer_address);
				case (oldest_reply.act)
					ACT_OFFER: offers_seen++;
					ACT_ACK:   acks_seen++;
					ACT_ALLOC: allocs_seen++;
					default:   drops_seen++;
				endcase
			end
		end
	end

	initial begin
		foreach (mac_pool[i]) mac_pool[i] = random_mac();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_header_drops();
		test_zero_mac();
		test_message_types();
		test_config_extremes();
		test_random_traffic();
		test_table_full();
		repeat (2 * NUM_LEASES + 4) @(posedge clk);
		$display("%0d commands under %0d register settings", commands_sent, settings_used);
		$display("results: %0d offers, %0d acks, %0d plain allocations, %0d drops",
			offers_seen, acks_seen, allocs_seen, drops_seen);
		if (fail_count == 0 && pending_replies.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
